/* rtl/core/sapq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sapq_pkg;

    // Store geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths
    localparam int FUNC_W   = 3;
    localparam int DATA_W   = 32;
    localparam int STAT_W   = 2;
    localparam int POS_W    = 4;
    localparam int FILL_W   = 5;

    // Stream widths, padded to whole bytes
    localparam int IN_BITS       = FUNC_W + 2 * DATA_W;
    localparam int IN_TDATA_W    = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS      = STAT_W + POS_W + DATA_W + FILL_W;
    localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_DELMAX = 3'd1;
    localparam logic [FUNC_W-1:0] FN_DELETE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_SEARCH = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CHANGE = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] new_value;
    } op_t;

    typedef struct packed {
        logic [FILL_W-1:0]        fill_count;
        logic signed [DATA_W-1:0] out_value;
        logic [POS_W-1:0]         position;
        logic [STAT_W-1:0]        status;
    } res_t;

endpackage

`default_nettype wire

/* rtl/core/sapq_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

module sapq_engine
    import sapq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire op_t  op,
    input  wire logic res_free,
    output logic      idle,
    output logic      res_valid,
    output res_t      res
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DMAX = 3'd1;
    localparam logic [2:0] ST_SRCH = 3'd2;
    localparam logic [2:0] ST_DEL  = 3'd3;
    localparam logic [2:0] ST_INS  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    // Midpoint of window [lo, rp-1]: lo + (r - lo) / 2
    function automatic logic [CNT_W-1:0] mid_of(input logic [CNT_W-1:0] lo,
                                                 input logic [CNT_W-1:0] rp);
        logic [CNT_W-1:0] span;
        span = rp - lo - 1'b1;
        return lo + (span >> 1);
    endfunction

    // Entry store, one write and one registered read per cycle
    logic signed [DATA_W-1:0] mem [CAPACITY];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic signed [DATA_W-1:0] wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Control state
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pend_reg, pend_next;

    // Working payload
    logic [FUNC_W-1:0]        func_reg, func_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic signed [DATA_W-1:0] nval_reg, nval_next;
    logic signed [DATA_W-1:0] ins_reg, ins_next;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    logic [CNT_W-1:0]         rp_reg, rp_next;
    logic [CNT_W-1:0]         ptr_reg, ptr_next;
    logic [IDX_W-1:0]         addr_reg, addr_next;
    logic [STAT_W-1:0]        stat_reg, stat_next;
    logic [IDX_W-1:0]         pos_reg, pos_next;
    logic signed [DATA_W-1:0] ov_reg, ov_next;

    // Binary search step on the returned entry
    logic             bs_lt;
    logic [CNT_W-1:0] bs_lo;
    logic [CNT_W-1:0] bs_rp;
    logic [CNT_W-1:0] bs_mid;
    logic [CNT_W-1:0] first_mid;
    logic [IDX_W-1:0] last_idx;

    always_comb
    begin
        bs_lt     = rd_data_reg < val_reg;
        bs_lo     = bs_lt ? (CNT_W'(addr_reg) + 1'b1) : lo_reg;
        bs_rp     = bs_lt ? rp_reg : CNT_W'(addr_reg);
        bs_mid    = mid_of(bs_lo, bs_rp);
        first_mid = mid_of(lo_reg, rp_reg);
        last_idx  = IDX_W'(cnt_reg - 1'b1);
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        func_next  = func_reg;
        val_next   = val_reg;
        nval_next  = nval_reg;
        ins_next   = ins_reg;
        lo_next    = lo_reg;
        rp_next    = rp_reg;
        ptr_next   = ptr_reg;
        addr_next  = addr_reg;
        stat_next  = stat_reg;
        pos_next   = pos_reg;
        ov_next    = ov_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = rd_data_reg;
        res_valid  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    func_next = op.func;
                    val_next  = op.value;
                    nval_next = op.new_value;
                    stat_next = STAT_OK;
                    pos_next  = '0;
                    ov_next   = op.value;
                    pend_next = 1'b0;
                    case (op.func)
                        FN_INSERT:
                        begin
                            if (cnt_reg >= CNT_W'(CAPACITY))
                            begin
                                stat_next  = STAT_FULL;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                ins_next   = op.value;
                                ptr_next   = cnt_reg;
                                state_next = ST_INS;
                            end
                        end
                        FN_DELMAX:
                        begin
                            if (cnt_reg == '0)
                            begin
                                stat_next  = STAT_EMPTY;
                                ov_next    = '0;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_DMAX;
                            end
                        end
                        FN_DELETE, FN_SEARCH, FN_CHANGE:
                        begin
                            lo_next    = '0;
                            rp_next    = cnt_reg;
                            state_next = ST_SRCH;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            // Read last entry, then drop it
            ST_DMAX:
            begin
                if (!pend_reg)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = last_idx;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    ov_next    = rd_data_reg;
                    pos_next   = last_idx;
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ST_DONE;
                end
            end

            // One probe per cycle; next address follows the returned entry
            ST_SRCH:
            begin
                if (!pend_reg)
                begin
                    if (lo_reg < rp_reg)
                    begin
                        rd_en     = 1'b1;
                        rd_addr   = IDX_W'(first_mid);
                        addr_next = IDX_W'(first_mid);
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        stat_next  = STAT_NOTFOUND;
                        state_next = ST_DONE;
                    end
                end
                else if (rd_data_reg == val_reg)
                begin
                    pend_next = 1'b0;
                    if (func_reg == FN_SEARCH)
                    begin
                        pos_next   = addr_reg;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        if (func_reg == FN_DELETE)
                        begin
                            pos_next = addr_reg;
                        end
                        ptr_next   = CNT_W'(addr_reg) + 1'b1;
                        state_next = ST_DEL;
                    end
                end
                else
                begin
                    lo_next = bs_lo;
                    rp_next = bs_rp;
                    if (bs_lo < bs_rp)
                    begin
                        rd_en     = 1'b1;
                        rd_addr   = IDX_W'(bs_mid);
                        addr_next = IDX_W'(bs_mid);
                    end
                    else
                    begin
                        pend_next  = 1'b0;
                        stat_next  = STAT_NOTFOUND;
                        state_next = ST_DONE;
                    end
                end
            end

            // Shift entries above the hit down by one
            ST_DEL:
            begin
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = addr_reg;
                    wr_data = rd_data_reg;
                end
                if (ptr_reg < cnt_reg)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = IDX_W'(ptr_reg);
                    addr_next = IDX_W'(ptr_reg - 1'b1);
                    ptr_next  = ptr_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    cnt_next  = cnt_reg - 1'b1;
                    if (func_reg == FN_CHANGE)
                    begin
                        ins_next   = nval_reg;
                        ptr_next   = cnt_reg - 1'b1;
                        state_next = ST_INS;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            // Walk down from the top, moving larger entries up one slot
            ST_INS:
            begin
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = addr_reg + 1'b1;
                    if (ins_reg < rd_data_reg)
                    begin
                        wr_data = rd_data_reg;
                        if (ptr_reg != '0)
                        begin
                            rd_en     = 1'b1;
                            rd_addr   = IDX_W'(ptr_reg - 1'b1);
                            addr_next = IDX_W'(ptr_reg - 1'b1);
                            ptr_next  = ptr_reg - 1'b1;
                        end
                        else
                        begin
                            pend_next = 1'b0;
                        end
                    end
                    else
                    begin
                        wr_data    = ins_reg;
                        pos_next   = addr_reg + 1'b1;
                        pend_next  = 1'b0;
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = ST_DONE;
                    end
                end
                else if (ptr_reg != '0)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = IDX_W'(ptr_reg - 1'b1);
                    addr_next = IDX_W'(ptr_reg - 1'b1);
                    ptr_next  = ptr_reg - 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    wr_data    = ins_reg;
                    pos_next   = '0;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_DONE;
                end
            end

            // Hand the result over once the output register is free
            ST_DONE:
            begin
                if (res_free)
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        val_reg  <= val_next;
        nval_reg <= nval_next;
        ins_reg  <= ins_next;
        lo_reg   <= lo_next;
        rp_reg   <= rp_next;
        ptr_reg  <= ptr_next;
        addr_reg <= addr_next;
        stat_reg <= stat_next;
        pos_reg  <= pos_next;
        ov_reg   <= ov_next;
    end

    assign idle = (state_reg == ST_IDLE);

    always_comb
    begin
        res.status     = stat_reg;
        res.position   = POS_W'(pos_reg);
        res.out_value  = ov_reg;
        res.fill_count = FILL_W'(cnt_reg);
    end

endmodule

`default_nettype wire

/* rtl/core/sorted_array_priority_queue_top.sv */
// Sorted-array priority queue: keeps up to CAPACITY (16) signed 32-bit values in
// ascending order in a single-port-read, single-port-write RAM and runs one
// operation per input transaction (insert, delete max, delete value, search,
// change), returning exactly one result transaction. Operations run one at a
// time; the input is ready again once the previous operation has handed its
// result to the output register, so a new transaction may be taken while an
// earlier result still waits downstream. Run time is set by the RAM walk, one entry
// per cycle with registered reads: delete max reads the last entry and drops it,
// search probes the store by binary search, insert walks down from the top to its
// position, delete value runs the search and then shifts the entries above the hit
// down, and change runs that delete and then an insert.
// The RAM needs no clearing after reset; only entries below the fill count are read.
`timescale 1ns / 1ps
`default_nettype none

module sorted_array_priority_queue_top
    import sapq_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // func[2:0], value[34:3], new_value[66:35], zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // status[1:0], position[5:2], out_value[37:6], fill_count[42:38], zero pad
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    logic eng_idle;
    logic eng_start;
    logic res_free;
    logic res_valid;
    op_t  op;
    res_t res;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Unpack input transaction
    always_comb
    begin
        op.func      = s_tdata[FUNC_W-1:0];
        op.value     = s_tdata[FUNC_W +: DATA_W];
        op.new_value = s_tdata[FUNC_W + DATA_W +: DATA_W];
    end

    assign s_tready  = eng_idle;
    assign eng_start = s_tvalid && eng_idle;
    assign res_free  = !m_tvalid_reg || m_tready;

    sapq_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (eng_start),
        .op        (op),
        .res_free  (res_free),
        .idle      (eng_idle),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_valid)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = OUT_TDATA_W'(res);
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

/* tb/tb_sorted_array_priority_queue_top.sv */
`timescale 1ns / 1ps

module tb_sorted_array_priority_queue_top;
    import sapq_pkg::*;

    // Func codes the block treats as no-ops
    localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE_MID = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

    localparam int V_MIN = 32'sh8000_0000;
    localparam int V_MAX = 32'sh7FFF_FFFF;
    localparam int RAND_ITEMS = 928;
    localparam int POOL_N = 8;
    localparam int PRINT_CAP = 40;

    typedef struct {
        op_t op;
        bit  hold;  // wait for all outstanding results before offering
    } pending_t;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // func[2:0], value[34:3], new_value[66:35], zero pad
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // status[1:0], position[5:2], out_value[37:6], fill_count[42:38], zero pad
    logic [OUT_TDATA_W-1:0] m_tdata;

    sorted_array_priority_queue_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Shadow of the queue contents
    int       shadow_store [CAPACITY];
    int       shadow_count = 0;

    pending_t pending_q[$];
    res_t     expected_q[$];
    int       value_pool [POOL_N];
    int       fail_count = 0;

    // Driver-side state
    op_t      offer_op;
    bit       offer_live = 1'b0;
    int       send_wait = 0;
    int       send_calm = 0;

    // Monitor-side state
    int       recv_wait = 0;
    int       recv_calm = 0;

    initial begin
        forever #4 clk = ~clk;
    end

    // Gap length: mostly none or short, a few long, with calm stretches of none
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Sorted insert after any equal entries; returns the slot used
    function automatic int shadow_insert(int v);
        int pos;
        pos = shadow_count;
        for (int i = 0; i < shadow_count; i++) begin
            if (v < shadow_store[i]) begin
                pos = i;
                break;
            end
        end
        for (int i = shadow_count; i > pos; i--)
            shadow_store[i] = shadow_store[i-1];
        shadow_store[pos] = v;
        shadow_count++;
        return pos;
    endfunction

    function automatic void shadow_remove(int idx);
        for (int i = idx; i + 1 < shadow_count; i++)
            shadow_store[i] = shadow_store[i+1];
        shadow_count--;
    endfunction

    // Apply one operation to the shadow and return the result it must produce
    function automatic res_t queue_result(op_t op);
        res_t r;
        int   v;
        int   lo;
        int   hi;
        int   mid;
        int   hit;
        v = op.value;
        r.status = STAT_OK;
        r.position = '0;
        r.out_value = op.value;
        case (op.func)
            FN_INSERT:
            begin
                if (shadow_count >= CAPACITY)
                    r.status = STAT_FULL;
                else
                    r.position = POS_W'(shadow_insert(v));
            end
            FN_DELMAX:
            begin
                if (shadow_count == 0) begin
                    r.status = STAT_EMPTY;
                    r.out_value = '0;
                end else begin
                    shadow_count--;
                    r.position = POS_W'(shadow_count);
                    r.out_value = shadow_store[shadow_count];
                end
            end
            FN_DELETE, FN_SEARCH, FN_CHANGE:
            begin
                // binary search, midpoint rounded toward the left bound
                hit = -1;
                lo = 0;
                hi = shadow_count - 1;
                while (lo <= hi && hit < 0) begin
                    mid = lo + (hi - lo) / 2;
                    if (shadow_store[mid] == v)
                        hit = mid;
                    else if (shadow_store[mid] < v)
                        lo = mid + 1;
                    else
                        hi = mid - 1;
                end
                if (hit < 0) begin
                    r.status = STAT_NOTFOUND;
                end else if (op.func == FN_SEARCH) begin
                    r.position = POS_W'(hit);
                end else if (op.func == FN_DELETE) begin
                    r.position = POS_W'(hit);
                    shadow_remove(hit);
                end else begin
                    shadow_remove(hit);
                    r.position = POS_W'(shadow_insert(op.new_value));
                end
            end
            default:
            begin
            end
        endcase
        r.fill_count = FILL_W'(shadow_count);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic queue_op(logic [FUNC_W-1:0] f, int v, int nv, bit hold = 1'b0);
        pending_t p;
        p.op.func = f;
        p.op.value = v;
        p.op.new_value = nv;
        p.hold = hold;
        pending_q.push_back(p);
    endtask

    // Pool hits are frequent; extremes and full-range values mixed in
    function automatic int draw_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return value_pool[$urandom_range(0, POOL_N - 1)];
        if (r < 75) begin
            case ($urandom_range(0, 3))
                0: return V_MIN;
                1: return V_MAX;
                2: return 0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    // Input driver: offers pending operations, predicts on each accepted transaction
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            offer_live = 1'b0;
            send_wait = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_q.push_back(queue_result(offer_op));
                offer_live = 1'b0;
                send_wait = pick_gap(send_calm);
            end
            if (!offer_live) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (pending_q.size() > 0 &&
                             !(pending_q[0].hold && expected_q.size() != 0)) begin
                    offer_op = pending_q[0].op;
                    void'(pending_q.pop_front());
                    offer_live = 1'b1;
                end
            end
            s_tvalid <= offer_live;
            if (offer_live)
                s_tdata <= IN_TDATA_W'({offer_op.new_value, offer_op.value, offer_op.func});
        end
    end

    // Result monitor: random backpressure, field-by-field compare
    always @(posedge clk) begin : result_monitor
        res_t got;
        res_t want;
        if (!rst_n) begin
            m_tready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata[OUT_BITS-1:0]);
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result transaction", got.status, -1);
                end else begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.position !== want.position)
                        report_mismatch("position", got.position, want.position);
                    if (got.out_value !== want.out_value)
                        report_mismatch("out_value", got.out_value, want.out_value);
                    if (got.fill_count !== want.fill_count)
                        report_mismatch("fill_count", got.fill_count, want.fill_count);
                end
                recv_wait = pick_gap(recv_calm);
            end else if (recv_wait > 0) begin
                recv_wait--;
            end
            m_tready <= (recv_wait == 0);
        end
    end

    // Stimulus and end of run
    initial begin
        int                phase;
        int                phase_len;
        int                gen_count;
        int                ins_pct;
        int                dmx_pct;
        int                r;
        logic [FUNC_W-1:0] f;
        mix_t              mode;

        // Empty queue corner cases and no-op codes
        queue_op(FN_DELMAX, 5, 0);
        queue_op(FN_SEARCH, 5, 0);
        queue_op(FN_DELETE, 5, 0);
        queue_op(FN_CHANGE, 5, 6);
        queue_op(FN_SPARE_LO, V_MIN, -1);
        queue_op(FN_SPARE_MID, 12345, V_MAX);
        queue_op(FN_SPARE_HI, V_MAX, V_MIN);
        // Extremes and duplicates
        queue_op(FN_INSERT, V_MAX, 0, 1'b1);
        queue_op(FN_INSERT, V_MIN, 0);
        queue_op(FN_INSERT, 0, 0);
        queue_op(FN_INSERT, 0, 0);
        queue_op(FN_INSERT, -1, 0);
        queue_op(FN_SEARCH, 0, 0);
        queue_op(FN_SEARCH, V_MIN, 0);
        queue_op(FN_SEARCH, V_MAX, 0);
        queue_op(FN_SEARCH, 1, 0);
        queue_op(FN_DELETE, -1, 0);
        // change onto an existing value lands after the equal one
        queue_op(FN_CHANGE, V_MIN, V_MAX);
        queue_op(FN_CHANGE, 42, 7);
        queue_op(FN_DELMAX, 0, 0);
        queue_op(FN_DELETE, 0, 0);
        queue_op(FN_DELMAX, 0, 0);

        // Random phases: fill-heavy, drain-heavy, balanced; first phase fills up
        gen_count = 0;
        phase = 0;
        while (gen_count < RAND_ITEMS) begin
            mode = (phase == 0) ? MIX_FILL : mix_t'($urandom_range(0, 2));
            phase_len = (phase == 0) ? 40 : $urandom_range(20, 60);
            case (mode)
                MIX_FILL:  begin ins_pct = 70; dmx_pct = 5;  end
                MIX_DRAIN: begin ins_pct = 15; dmx_pct = 35; end
                default:   begin ins_pct = 35; dmx_pct = 15; end
            endcase
            for (int k = 0; k < POOL_N; k++)
                value_pool[k] = ($urandom_range(0, 3) == 0) ? int'($urandom)
                                                             : $urandom_range(0, 16) - 8;
            for (int n = 0; n < phase_len && gen_count < RAND_ITEMS; n++) begin
                gen_count++;
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    f = FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < ins_pct)
                        f = FN_INSERT;
                    else if (r < ins_pct + dmx_pct)
                        f = FN_DELMAX;
                    else begin
                        case ($urandom_range(0, 2))
                            0: f = FN_DELETE;
                            1: f = FN_SEARCH;
                            default: f = FN_CHANGE;
                        endcase
                    end
                end
                queue_op(f, draw_value(), draw_value(),
                         n == 0 && (phase == 0 || $urandom_range(0, 2) == 0));
            end
            phase++;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || offer_live)
            @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
